// ----- rtl/tdp_pkg.sv -----
`timescale 1ns / 1ps

package tdp_pkg;

	// Default width of the candidate number
	localparam int NUMBER_WIDTH_DEF = 32;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_CHECK,
		ST_FINISH
	} state_t;

	// Strobes from the sequencer's output decode
	typedef struct packed {
		logic in_ready;
		logic div_start;
	} seq_ctl_t;

endpackage

// ----- rtl/trial_division_prime_test_unit.sv -----
`timescale 1ns / 1ps

// Trial-division primality test. Each accepted item carries one signed number;
// the block returns one item with is_prime set when that number is prime.
// Numbers below two, every negative value included, answer 0 without the
// divider once the output register is free. Otherwise divisors
// d = 2, 3, 4, ... are tried in turn on one shared restoring divider that
// retires one quotient bit per cycle; the search stops at the first zero
// remainder (not prime) or once d exceeds number / d (prime). A prime runs
// floor(sqrt(number)) divisors, the last one only to find d past the root.
// in_ready is high only while the sequencer is idle; the finished result sits
// in an output register, so the next item may enter while it waits to be taken.

module trial_division_prime_test_unit #(
	parameter int NUMBER_WIDTH = tdp_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [NUMBER_WIDTH-1:0] number,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           is_prime
);
	import tdp_pkg::*;

	localparam int W = NUMBER_WIDTH;

	state_t       state_q;
	state_t       state_nxt;
	seq_ctl_t     ctl;

	logic [W-1:0] v_q;      // candidate under test
	logic [W-1:0] d_q;      // current trial divisor
	logic         res_q;    // verdict waiting for the output register
	logic         out_valid_q;
	logic         is_prime_q;

	logic         div_done;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;

	logic         in_acc;
	logic         trivial;  // negative, zero or one
	logic         past_root;
	logic         rem_zero;
	logic         out_free;

	assign in_acc    = in_valid && ctl.in_ready;
	assign trivial   = number[W-1] || (number[W-1:1] == '0);
	assign past_root = (d_q > div_quo);
	assign rem_zero  = (div_rem == '0);
	assign out_free  = !out_valid_q || out_ready;

	// Shared divider: computes v / d and v % d for the current divisor
	tdp_divider #(
		.W(W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (v_q),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nxt = trivial ? ST_FINISH : ST_START;
				end
			end
			ST_START: begin
				state_nxt = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (past_root || rem_zero) begin
					state_nxt = ST_FINISH;
				end else begin
					state_nxt = ST_START;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Output decode
	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE:  ctl.in_ready  = 1'b1;
			ST_START: ctl.div_start = 1'b1;
			default:  ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// Hand the verdict over once the output register is free
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q   <= $unsigned(number);
			d_q   <= W'(2);
			res_q <= 1'b0;
		end
		if (state_q == ST_CHECK) begin
			if (past_root) begin
				res_q <= 1'b1;
			end else if (rem_zero) begin
				res_q <= 1'b0;
			end else begin
				d_q <= d_q + W'(1);
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			is_prime_q <= res_q;
		end
	end

	assign in_ready  = ctl.in_ready;
	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

endmodule

// ----- rtl/tdp_divider.sv -----
`timescale 1ns / 1ps

module tdp_divider #(
	parameter int W = tdp_pkg::NUMBER_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	import tdp_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;

	logic [W:0]    rem_sh;
	logic [W:0]    diff;
	logic          ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, quo_q[W-1]};
		diff   = rem_sh - {1'b0, divisor};
		ge     = (rem_sh >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
